/* design/hcm_pkg.sv */
// Shared types and constants for the HSV cone colour mask unit.
// No dependencies; hcm_front, hcm_back and the top level import this package.
package hcm_pkg;

  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CHAN_W    = 8;
  localparam int QUOT_W    = 8;
  localparam int HNUM_W    = 17;
  localparam int HDEN_W    = 9;
  localparam int SNUM_W    = 16;

  localparam logic [CFG_IDX_W-1:0] IDX_YELLOW_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_YELLOW_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_BLUE_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_BLUE_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_REFLECT_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_REFLECT_HIGH = 3'd5;

  localparam logic [REG_W-1:0] RST_YELLOW_LOW   = 24'h14647C;
  localparam logic [REG_W-1:0] RST_YELLOW_HIGH  = 24'h2DEBFF;
  localparam logic [REG_W-1:0] RST_BLUE_LOW     = 24'h6D4434;
  localparam logic [REG_W-1:0] RST_BLUE_HIGH    = 24'h87FAFF;
  localparam logic [REG_W-1:0] RST_REFLECT_LOW  = 24'h003200;
  localparam logic [REG_W-1:0] RST_REFLECT_HIGH = 24'hB350FF;

  localparam logic [QUOT_W-1:0] HUE_WRAP = 8'd180;

  typedef struct packed {
    logic [HNUM_W-1:0] hue_num;
    logic [HDEN_W-1:0] hue_den;
    logic [SNUM_W-1:0] sat_num;
    logic [CHAN_W-1:0] sat_den;
    logic [CHAN_W-1:0] val;
  } hcm_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] val;
    logic              yellow;
    logic              blue;
  } hcm_result_t;

  typedef struct packed {
    logic [REG_W-1:0] yellow_low;
    logic [REG_W-1:0] yellow_high;
    logic [REG_W-1:0] blue_low;
    logic [REG_W-1:0] blue_high;
    logic [REG_W-1:0] reflect_low;
    logic [REG_W-1:0] reflect_high;
  } hcm_cfg_t;

endpackage

/* design/hcm_fifo.sv */
// Small register-based first-in first-out queue of generic width and depth.
// Depends on nothing; used between the front and back and at the result side.
module hcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* design/hcm_front.sv */
// Front end: accepts a pixel, finds max, min and the hue sector, and forms
// the numerators and divisors for hue and saturation. Depends on hcm_pkg.
module hcm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [7:0]                blue_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                red_i,
  input  logic                      stall_i,
  output logic                      vld_o,
  output hcm_pkg::hcm_item_t        item_o
);
  import hcm_pkg::*;

  logic              vld_q, vld_d;
  hcm_item_t         item_q, item_d;
  logic              accept, hand_off;
  logic [CHAN_W-1:0] mx, mn, d;
  logic [10:0]       d6, t;

  assign hand_off = vld_q && !stall_i;
  assign full_o   = vld_q && stall_i;
  assign accept   = push_i && !full_o;
  assign vld_o    = vld_q;
  assign item_o   = item_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) begin
      mx = green_i;
    end
    if (blue_i > mx) begin
      mx = blue_i;
    end
    if (green_i < mn) begin
      mn = green_i;
    end
    if (blue_i < mn) begin
      mn = blue_i;
    end
    d  = mx - mn;
    d6 = {2'b0, d, 1'b0} + {1'b0, d, 2'b0};
    priority if (mx == red_i) begin
      if (green_i >= blue_i) begin
        t = {3'b0, green_i} - {3'b0, blue_i};
      end else begin
        t = d6 - ({3'b0, blue_i} - {3'b0, green_i});
      end
    end else if (mx == green_i) begin
      t = {3'b0, blue_i} + {2'b0, d, 1'b0} - {3'b0, red_i};
    end else begin
      t = {3'b0, red_i} + {1'b0, d, 2'b0} - {3'b0, green_i};
    end
    item_d.hue_num = {t, 6'b0} - {4'b0, t, 2'b0} + {9'b0, d};
    item_d.hue_den = (d == '0) ? HDEN_W'(1) : {d, 1'b0};
    item_d.sat_num = {d, 8'b0} - {8'b0, d} + {9'b0, mx[7:1]};
    item_d.sat_den = (mx == '0) ? CHAN_W'(1) : mx;
    item_d.val     = mx;
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (hand_off) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

/* design/hcm_back.sv */
// Back end: pipelined restoring division for hue and saturation, the three
// box tests and the result queue. Depends on hcm_pkg and hcm_fifo.
module hcm_back #(
  parameter int OUT_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hcm_pkg::hcm_cfg_t    cfg_i,
  input  logic                 mid_empty_i,
  input  hcm_pkg::hcm_item_t   mid_item_i,
  output logic                 mid_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output hcm_pkg::hcm_result_t res_o
);
  import hcm_pkg::*;

  localparam int NStages = QUOT_W;
  localparam int CntW    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [HNUM_W-1:0] hue_rem;
    logic [HDEN_W-1:0] hue_den;
    logic [QUOT_W-1:0] hue_q;
    logic [SNUM_W-1:0] sat_rem;
    logic [CHAN_W-1:0] sat_den;
    logic [QUOT_W-1:0] sat_q;
    logic [CHAN_W-1:0] val;
  } div_t;

  function automatic logic in_box(logic [REG_W-1:0] lo, logic [REG_W-1:0] hi,
                                  logic [CHAN_W-1:0] h, logic [CHAN_W-1:0] s,
                                  logic [CHAN_W-1:0] v);
    return (h >= lo[23:16]) && (h <= hi[23:16]) &&
           (s >= lo[15:8])  && (s <= hi[15:8])  &&
           (v >= lo[7:0])   && (v <= hi[7:0]);
  endfunction

  div_t              st_q [NStages+1];
  div_t              st_d [NStages+1];
  logic [NStages:0]  vld_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              issue, out_pop, out_full, out_push;
  logic [HNUM_W-1:0] hue_sub;
  logic [SNUM_W-1:0] sat_sub;
  hcm_result_t       res_d;
  logic              yel, blu, refl;

  assign issue     = !mid_empty_i && (cnt_q < CntW'(OUT_DEPTH));
  assign mid_pop_o = issue;
  assign out_pop   = pop_i && !empty_o;
  assign out_push  = vld_q[NStages] && !out_full;

  always_comb begin
    st_d[0].hue_rem = mid_item_i.hue_num;
    st_d[0].hue_den = mid_item_i.hue_den;
    st_d[0].hue_q   = '0;
    st_d[0].sat_rem = mid_item_i.sat_num;
    st_d[0].sat_den = mid_item_i.sat_den;
    st_d[0].sat_q   = '0;
    st_d[0].val     = mid_item_i.val;
    hue_sub = '0;
    sat_sub = '0;
    for (int k = 0; k < NStages; k++) begin
      st_d[k+1] = st_q[k];
      hue_sub = HNUM_W'({{(HNUM_W-HDEN_W){1'b0}}, st_q[k].hue_den} << (NStages-1-k));
      sat_sub = SNUM_W'({{(SNUM_W-CHAN_W){1'b0}}, st_q[k].sat_den} << (NStages-1-k));
      if (st_q[k].hue_rem >= hue_sub) begin
        st_d[k+1].hue_rem = st_q[k].hue_rem - hue_sub;
        st_d[k+1].hue_q   = {st_q[k].hue_q[QUOT_W-2:0], 1'b1};
      end else begin
        st_d[k+1].hue_q   = {st_q[k].hue_q[QUOT_W-2:0], 1'b0};
      end
      if (st_q[k].sat_rem >= sat_sub) begin
        st_d[k+1].sat_rem = st_q[k].sat_rem - sat_sub;
        st_d[k+1].sat_q   = {st_q[k].sat_q[QUOT_W-2:0], 1'b1};
      end else begin
        st_d[k+1].sat_q   = {st_q[k].sat_q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    res_d.hue = (st_q[NStages].hue_q == HUE_WRAP) ? '0 : st_q[NStages].hue_q;
    res_d.sat = st_q[NStages].sat_q;
    res_d.val = st_q[NStages].val;
    yel  = in_box(cfg_i.yellow_low, cfg_i.yellow_high, res_d.hue, res_d.sat, res_d.val);
    blu  = in_box(cfg_i.blue_low, cfg_i.blue_high, res_d.hue, res_d.sat, res_d.val);
    refl = in_box(cfg_i.reflect_low, cfg_i.reflect_high, res_d.hue, res_d.sat, res_d.val);
    res_d.yellow = yel;
    res_d.blue   = blu && !refl;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (issue && !out_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (out_pop && !issue) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else begin
      vld_q <= {vld_q[NStages-1:0], issue};
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NStages; k++) begin
      st_q[k] <= st_d[k];
    end
  end

  hcm_fifo #(
    .WIDTH($bits(hcm_result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(res_d),
    .full_o (out_full),
    .pop_i  (pop_i),
    .rdata_o(res_o),
    .empty_o(empty_o)
  );

endmodule

/* design/hsv_cone_colour_mask_unit.sv */
// Top level of the HSV cone colour mask unit: configuration registers, front
// end, mid queue and back end. Depends on hcm_pkg, hcm_front, hcm_fifo, hcm_back.
//
// Each beat pushed in is one BGR pixel; each beat popped out gives its hue
// (half degrees), saturation, value and the yellow and blue masks, in order.
// The unit takes one pixel every cycle and delivers one result every cycle
// for as long as results are popped. From push, a pixel passes the front
// register, the mid queue, the divider input register and the stages of the
// one-bit-per-stage divider for hue and saturation, and then enters the result
// queue. The result queue of OUT_DEPTH entries holds all pixels in flight, so
// a stalled consumer never loses one.
// The box bounds are read as they stand and should be written only while idle.
module hsv_cone_colour_mask_unit #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] red_in_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] hue_out_o,
  output logic [7:0] sat_out_o,
  output logic [7:0] val_out_o,
  output logic       yellow_mask_o,
  output logic       blue_mask_o,
  input  logic       cfg_we_i,
  input  logic [hcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hcm_pkg::REG_W-1:0]     cfg_data_i
);
  import hcm_pkg::*;

  hcm_cfg_t    cfg_q;
  hcm_item_t   front_item, mid_item;
  hcm_result_t res;
  logic        front_vld, mid_full, mid_empty, mid_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.yellow_low   <= RST_YELLOW_LOW;
      cfg_q.yellow_high  <= RST_YELLOW_HIGH;
      cfg_q.blue_low     <= RST_BLUE_LOW;
      cfg_q.blue_high    <= RST_BLUE_HIGH;
      cfg_q.reflect_low  <= RST_REFLECT_LOW;
      cfg_q.reflect_high <= RST_REFLECT_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        IDX_YELLOW_LOW:   cfg_q.yellow_low   <= cfg_data_i;
        IDX_YELLOW_HIGH:  cfg_q.yellow_high  <= cfg_data_i;
        IDX_BLUE_LOW:     cfg_q.blue_low     <= cfg_data_i;
        IDX_BLUE_HIGH:    cfg_q.blue_high    <= cfg_data_i;
        IDX_REFLECT_LOW:  cfg_q.reflect_low  <= cfg_data_i;
        IDX_REFLECT_HIGH: cfg_q.reflect_high <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  hcm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .blue_i (blue_in_i),
    .green_i(green_in_i),
    .red_i  (red_in_i),
    .stall_i(mid_full),
    .vld_o  (front_vld),
    .item_o (front_item)
  );

  hcm_fifo #(
    .WIDTH($bits(hcm_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_vld),
    .wdata_i(front_item),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .rdata_o(mid_item),
    .empty_o(mid_empty)
  );

  hcm_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .mid_empty_i(mid_empty),
    .mid_item_i (mid_item),
    .mid_pop_o  (mid_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  assign hue_out_o     = res.hue;
  assign sat_out_o     = res.sat;
  assign val_out_o     = res.val;
  assign yellow_mask_o = res.yellow;
  assign blue_mask_o   = res.blue;

endmodule

/* test/tb_hsv_cone_colour_mask_unit.sv */
// Self-checking testbench for hsv_cone_colour_mask_unit: BGR pixels in, HSV and colour masks out.
// Depends on hcm_pkg and the unit itself; it keeps its own HSV and box-test predictor.
// Results are checked in order over several register settings and idling modes.
`timescale 1ns / 1ps

module tb_hsv_cone_colour_mask_unit;
  import hcm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 24;
  localparam int DIRECTED_COUNT = 22;
  localparam int RANDOM_PER_PHASE = 150;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [7:0]           blue_in_i;
  logic [7:0]           green_in_i;
  logic [7:0]           red_in_i;
  logic                 empty;
  logic                 pop;
  logic [7:0]           hue_out_o;
  logic [7:0]           sat_out_o;
  logic [7:0]           val_out_o;
  logic                 yellow_mask_o;
  logic                 blue_mask_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_data_i;

  logic [REG_W-1:0] box_bound [0:5];
  hcm_result_t      expected_hsv [$];
  int               idle_pct;
  int               stall_pct;
  int               hold_cycles;
  int               failures;
  int               pixels_sent;
  int               results_checked;
  int               reg_writes;

  hsv_cone_colour_mask_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .blue_in_i     (blue_in_i),
    .green_in_i    (green_in_i),
    .red_in_i      (red_in_i),
    .empty         (empty),
    .pop           (pop),
    .hue_out_o     (hue_out_o),
    .sat_out_o     (sat_out_o),
    .val_out_o     (val_out_o),
    .yellow_mask_o (yellow_mask_o),
    .blue_mask_o   (blue_mask_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic in_hsv_box(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
                                      input logic [7:0] h, input logic [7:0] s,
                                      input logic [7:0] v);
    return (h >= lo[23:16]) && (h <= hi[23:16]) && (s >= lo[15:8]) && (s <= hi[15:8]) &&
           (v >= lo[7:0]) && (v <= hi[7:0]);
  endfunction

  function automatic hcm_result_t predict_hsv_mask(input logic [23:0] px);
    int b, g, r, v, mn, d, t, hue, sat;
    hcm_result_t res;
    b = int'(px[23:16]);
    g = int'(px[15:8]);
    r = int'(px[7:0]);
    v = r;
    mn = r;
    if (g > v) v = g;
    if (b > v) v = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = v - mn;
    hue = 0;
    sat = 0;
    if (d > 0) begin
      if (v == r) t = g - b;
      else if (v == g) t = b - r + 2 * d;
      else t = r - g + 4 * d;
      if (t < 0) t = t + 6 * d;
      hue = (60 * t + d) / (2 * d);
      if (hue >= int'(HUE_WRAP)) hue = hue - int'(HUE_WRAP);
    end
    if (v > 0) sat = (255 * d + v / 2) / v;
    res.hue = hue[7:0];
    res.sat = sat[7:0];
    res.val = v[7:0];
    res.yellow = in_hsv_box(box_bound[IDX_YELLOW_LOW], box_bound[IDX_YELLOW_HIGH],
                            res.hue, res.sat, res.val);
    res.blue = in_hsv_box(box_bound[IDX_BLUE_LOW], box_bound[IDX_BLUE_HIGH],
                          res.hue, res.sat, res.val) &&
               !in_hsv_box(box_bound[IDX_REFLECT_LOW], box_bound[IDX_REFLECT_HIGH],
                           res.hue, res.sat, res.val);
    return res;
  endfunction

  // Pixels are packed as {blue, green, red}.
  function automatic logic [23:0] directed_pixel(input int n);
    case (n)
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h808080;
      3:       return 24'h010101;
      4:       return 24'h0000FF;
      5:       return 24'h00FF00;
      6:       return 24'hFF0000;
      7:       return 24'h0100FF;
      8:       return 24'h00FFFF;
      9:       return 24'hFFFF00;
      10:      return 24'hFF00FF;
      11:      return 24'h000001;
      12:      return 24'hC86432;
      13:      return 24'hC8968C;
      14:      return 24'h28C8DC;
      15:      return 24'h7F7F80;
      16:      return 24'h01FEFF;
      17:      return 24'h80FF00;
      18:      return 24'hFE00FF;
      19:      return 24'h00FF80;
      20:      return 24'h55AA00;
      default: return 24'hFFFE01;
    endcase
  endfunction

  function automatic logic [23:0] random_pixel();
    logic [7:0]  a;
    logic [7:0]  c;
    logic [23:0] px;
    a = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    px = 24'($urandom);
    case ($urandom_range(0, 9))
      0:       px = {a, a, a};
      1:       px = {c, a, a};
      2:       px = {a, c, a};
      3:       px = {a, a, c};
      default: ;
    endcase
    return px;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx <= IDX_REFLECT_HIGH) box_bound[idx] = data;
    reg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [23:0] px);
    logic taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    blue_in_i <= px[23:16];
    green_in_i <= px[15:8];
    red_in_i <= px[7:0];
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
    expected_hsv.push_back(predict_hsv_mask(px));
    pixels_sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_hsv.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_box(input logic [CFG_IDX_W-1:0] lo_idx,
                            input logic [CFG_IDX_W-1:0] hi_idx);
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi;
    logic [7:0]       a;
    logic [7:0]       c;
    logic [7:0]       tmp;
    for (int k = 0; k < 3; k++) begin
      a = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        a = 8'd0;
        c = 8'd255;
      end else if (a > c && $urandom_range(0, 9) != 0) begin
        tmp = a;
        a = c;
        c = tmp;
      end
      lo[8*k +: 8] = a;
      hi[8*k +: 8] = c;
    end
    write_reg(lo_idx, lo);
    write_reg(hi_idx, hi);
  endtask

  task automatic write_all_boxes(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
    write_reg(IDX_YELLOW_LOW, lo);
    write_reg(IDX_YELLOW_HIGH, hi);
    write_reg(IDX_BLUE_LOW, lo);
    write_reg(IDX_BLUE_HIGH, hi);
    write_reg(IDX_REFLECT_LOW, lo);
    write_reg(IDX_REFLECT_HIGH, hi);
  endtask

  task automatic send_directed_set();
    for (int n = 0; n < DIRECTED_COUNT; n++) send_pixel(directed_pixel(n));
    wait_idle();
  endtask

  task automatic test_reset_defaults();
    idle_pct = 0;
    stall_pct = 0;
    send_directed_set();
  endtask

  task automatic test_register_extremes();
    write_all_boxes(24'h000000, 24'h000000);
    send_directed_set();
    write_all_boxes(24'h000000, 24'hFFFFFF);
    write_reg(IDX_REFLECT_LOW, 24'hFFFFFF);
    write_reg(IDX_SPARE_LO, 24'h000000);
    write_reg(IDX_SPARE_HI, 24'hFFFFFF);
    send_directed_set();
    write_reg(IDX_YELLOW_LOW, 24'h2D0000);
    write_reg(IDX_YELLOW_HIGH, 24'h14FFFF);
    write_reg(IDX_BLUE_LOW, RST_BLUE_LOW);
    write_reg(IDX_BLUE_HIGH, RST_BLUE_HIGH);
    write_reg(IDX_REFLECT_LOW, 24'h00FF00);
    write_reg(IDX_REFLECT_HIGH, 24'hFF00FF);
    send_directed_set();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      if (phase == 0) begin
        write_reg(IDX_YELLOW_LOW, RST_YELLOW_LOW);
        write_reg(IDX_YELLOW_HIGH, RST_YELLOW_HIGH);
        write_reg(IDX_BLUE_LOW, RST_BLUE_LOW);
        write_reg(IDX_BLUE_HIGH, RST_BLUE_HIGH);
        write_reg(IDX_REFLECT_LOW, RST_REFLECT_LOW);
        write_reg(IDX_REFLECT_HIGH, RST_REFLECT_HIGH);
      end else begin
        random_box(IDX_YELLOW_LOW, IDX_YELLOW_HIGH);
        random_box(IDX_BLUE_LOW, IDX_BLUE_HIGH);
        random_box(IDX_REFLECT_LOW, IDX_REFLECT_HIGH);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_pixel(random_pixel());
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    for (int n = 0; n < 80; n++) send_pixel(random_pixel());
    wait_idle();
  endtask

  initial begin : result_monitor
    hcm_result_t got;
    hcm_result_t want;
    logic        taken;
    pop <= 1'b0;
    forever begin
      @(negedge clk_i);
      taken = rst_ni && pop && !empty;
      if (taken) begin
        got = {hue_out_o, sat_out_o, val_out_o, yellow_mask_o, blue_mask_o};
        if (expected_hsv.size() == 0) begin
          $error("Result beat with no pixel outstanding: hue_out %0d sat_out %0d val_out %0d",
                 got.hue, got.sat, got.val);
          failures++;
        end else begin
          want = expected_hsv.pop_front();
          results_checked++;
          if (got.hue !== want.hue) begin
            $error("hue_out: expected %0d, got %0d", want.hue, got.hue);
            failures++;
          end
          if (got.sat !== want.sat) begin
            $error("sat_out: expected %0d, got %0d", want.sat, got.sat);
            failures++;
          end
          if (got.val !== want.val) begin
            $error("val_out: expected %0d, got %0d", want.val, got.val);
            failures++;
          end
          if (got.yellow !== want.yellow) begin
            $error("yellow_mask: expected %0b, got %0b", want.yellow, got.yellow);
            failures++;
          end
          if (got.blue !== want.blue) begin
            $error("blue_mask: expected %0b, got %0b", want.blue, got.blue);
            failures++;
          end
        end
      end
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", expected_hsv.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    failures = 0;
    pixels_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    hold_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    box_bound[IDX_YELLOW_LOW] = RST_YELLOW_LOW;
    box_bound[IDX_YELLOW_HIGH] = RST_YELLOW_HIGH;
    box_bound[IDX_BLUE_LOW] = RST_BLUE_LOW;
    box_bound[IDX_BLUE_HIGH] = RST_BLUE_HIGH;
    box_bound[IDX_REFLECT_LOW] = RST_REFLECT_LOW;
    box_bound[IDX_REFLECT_HIGH] = RST_REFLECT_HIGH;
    rst_ni <= 1'b0;
    push <= 1'b0;
    blue_in_i <= 8'd0;
    green_in_i <= 8'd0;
    red_in_i <= 8'd0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= IDX_YELLOW_LOW;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    wait_idle();

    $display("Sent %0d pixels and checked %0d result beats after %0d register writes,",
             pixels_sent, results_checked, reg_writes);
    $display("covering default, extreme, empty and random boxes under four idling modes.");
    if (failures == 0 && expected_hsv.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", failures, expected_hsv.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
